// ----- hdl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon crossing block.
// Used by pip_front, pip_queue, pip_back and point_in_polygon_crossing.
// No dependencies.
package pip_pkg;

  // Coordinate, ray and count widths fixed by the payload fields
  localparam int unsigned COORD_W = 24;
  localparam int unsigned RAY_W   = 23;
  localparam int unsigned CNT_W   = 7;

  // Ray length after reset: 10.0 in unsigned Q7.16
  localparam logic [RAY_W-1:0] RAY_RESET = RAY_W'(655360);

  // Default depth of the edge queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Input item
  typedef struct packed {
    logic signed [COORD_W-1:0] point_u;
    logic signed [COORD_W-1:0] point_v;
    logic signed [COORD_W-1:0] vertex_u;
    logic signed [COORD_W-1:0] vertex_v;
    logic                      last_vertex;
  } pip_in_t;

  // Result item
  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } pip_out_t;

  // One polygon edge, from (cu,cv) to (nu,nv)
  typedef struct packed {
    logic signed [COORD_W-1:0] cu;
    logic signed [COORD_W-1:0] cv;
    logic signed [COORD_W-1:0] nu;
    logic signed [COORD_W-1:0] nv;
  } pip_edge_t;

  // Queue entry: the work of one input item
  typedef struct packed {
    logic                      first;   // opens a polygon, count restarts
    logic                      a_vld;   // edge from previous vertex is present
    logic                      last;    // closing edge present, result due
    logic signed [COORD_W-1:0] qu;
    logic signed [COORD_W-1:0] qv;
    pip_edge_t                 ea;      // previous -> current vertex
    pip_edge_t                 eb;      // current -> first vertex
  } pip_entry_t;

endpackage

// ----- hdl/point_in_polygon_crossing.sv -----
// Point-in-polygon crossing test, one vertex item per cycle sustained unless
// a result waits on a stalled output. A last vertex's result is registered in
// the queue, pipeline stages 1 and 2 and the result register. The three-stage
// edge pipeline in pip_back tests both edges of a closing item side by side.
// Reset: async active low; ray length returns to 10.0, next item opens a polygon.
// Depends on pip_pkg, pip_front, pip_queue, pip_back.
module point_in_polygon_crossing #(
  parameter int unsigned QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pip_pkg::pip_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pip_pkg::pip_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pip_pkg::RAY_W-1:0] cfg_data_i
);

  logic [pip_pkg::RAY_W-1:0] ray_q;
  logic                      push, full, q_valid, q_pop;
  pip_pkg::pip_entry_t       push_entry, q_entry;

  // Ray length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= pip_pkg::RAY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ray_q <= cfg_data_i;
    end
  end

  pip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  pip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .valid_o     (q_valid),
    .data_o      (q_entry),
    .pop_i       (q_pop)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_i       (ray_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/pip_front.sv -----
// Front end: accepts vertex items, tracks polygon state, forms edge entries.
// Depends on pip_pkg.
module pip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pip_pkg::pip_in_t    in_data_i,
  output logic                push_o,
  output pip_pkg::pip_entry_t entry_o,
  input  logic                full_i
);

  logic                              awaiting_q, awaiting_d;
  logic signed [pip_pkg::COORD_W-1:0] first_u_q, first_v_q;
  logic signed [pip_pkg::COORD_W-1:0] prev_u_q, prev_v_q;
  logic signed [pip_pkg::COORD_W-1:0] query_u_q, query_v_q;
  logic                              xfer;

  assign in_ready_o = !full_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign push_o     = xfer;

  // Entry built from the item and the stored polygon state
  always_comb begin
    entry_o       = '0;
    entry_o.first = awaiting_q;
    entry_o.a_vld = !awaiting_q;
    entry_o.last  = in_data_i.last_vertex;
    entry_o.qu    = awaiting_q ? in_data_i.point_u : query_u_q;
    entry_o.qv    = awaiting_q ? in_data_i.point_v : query_v_q;
    entry_o.ea.cu = prev_u_q;
    entry_o.ea.cv = prev_v_q;
    entry_o.ea.nu = in_data_i.vertex_u;
    entry_o.ea.nv = in_data_i.vertex_v;
    entry_o.eb.cu = in_data_i.vertex_u;
    entry_o.eb.cv = in_data_i.vertex_v;
    entry_o.eb.nu = awaiting_q ? in_data_i.vertex_u : first_u_q;
    entry_o.eb.nv = awaiting_q ? in_data_i.vertex_v : first_v_q;
  end

  // A last vertex closes the polygon; the next item opens a new one
  always_comb begin
    awaiting_d = awaiting_q;
    if (xfer) begin
      awaiting_d = in_data_i.last_vertex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
    end else begin
      awaiting_q <= awaiting_d;
    end
  end

  // Vertex and query point storage
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      prev_u_q <= in_data_i.vertex_u;
      prev_v_q <= in_data_i.vertex_v;
      if (awaiting_q) begin
        first_u_q <= in_data_i.vertex_u;
        first_v_q <= in_data_i.vertex_v;
        query_u_q <= in_data_i.point_u;
        query_v_q <= in_data_i.point_v;
      end
    end
  end

endmodule

// ----- hdl/pip_queue.sv -----
// Short FIFO of edge entries between front and back.
// Depends on pip_pkg.
module pip_queue #(
  parameter int unsigned DEPTH = pip_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pip_pkg::pip_entry_t push_data_i,
  output logic                full_o,
  output logic                valid_o,
  output pip_pkg::pip_entry_t data_o,
  input  logic                pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pip_pkg::pip_entry_t mem_q [DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/pip_back.sv -----
// Back end: three-stage edge test pipeline, crossing count and result register.
// Depends on pip_pkg.
module pip_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pip_pkg::RAY_W-1:0]     ray_i,
  input  logic                          q_valid_i,
  input  pip_pkg::pip_entry_t           q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pip_pkg::pip_out_t             out_data_o
);

  localparam int unsigned CW  = pip_pkg::COORD_W;
  localparam int unsigned D   = CW + 1;
  localparam int unsigned SW  = ((CW > pip_pkg::RAY_W) ? CW : pip_pkg::RAY_W + 1) + 1;
  localparam int unsigned DU2 = SW + 1;
  localparam int unsigned PW  = DU2 + D;
  localparam int unsigned AW  = PW + 1;
  localparam int unsigned NW  = pip_pkg::CNT_W;

  // Differences and early rejects of one edge
  typedef struct packed {
    logic                  ok;
    logic signed [D-1:0]   du;
    logic signed [DU2-1:0] du2;
    logic signed [D-1:0]   dv;
    logic signed [D-1:0]   eu;
    logic signed [D-1:0]   ev;
  } s1_edge_t;

  // Products of one edge
  typedef struct packed {
    logic                 ok;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
  } s2_edge_t;

  function automatic s1_edge_t prep(pip_pkg::pip_edge_t e, logic vld,
                                    logic signed [CW-1:0] qu, logic signed [CW-1:0] qv,
                                    logic signed [SW-1:0] u2, logic ray_nz);
    s1_edge_t r;
    logic     skip;
    logic     rej;
    skip = (qv == e.cv && qv == e.nv) || (e.cv < e.nv && qv == e.nv) ||
           (e.cv > e.nv && qv == e.cv);
    rej  = ray_nz && ((e.cv > qv && e.nv > qv) || (e.cv < qv && e.nv < qv));
    r.ok  = vld && !skip && !rej;
    r.du  = D'(qu) - D'(e.cu);
    r.du2 = DU2'(u2) - DU2'(e.cu);
    r.dv  = D'(e.nv) - D'(e.cv);
    r.eu  = D'(e.nu) - D'(e.cu);
    r.ev  = D'(qv) - D'(e.cv);
    return r;
  endfunction

  function automatic s2_edge_t mult(s1_edge_t s);
    s2_edge_t r;
    r.ok = s.ok;
    r.p1 = PW'(s.du) * PW'(s.dv);
    r.p2 = PW'(s.du2) * PW'(s.dv);
    r.p3 = PW'(s.eu) * PW'(s.ev);
    return r;
  endfunction

  // Edge counts when the segment ends do not lie strictly on one side
  function automatic logic crosses(s2_edge_t s);
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] a2;
    logic                 pos1, neg1, pos2, neg2;
    a1   = AW'(s.p1) - AW'(s.p3);
    a2   = AW'(s.p2) - AW'(s.p3);
    neg1 = a1[AW-1];
    neg2 = a2[AW-1];
    pos1 = !neg1 && (a1 != '0);
    pos2 = !neg2 && (a2 != '0);
    return s.ok && !((pos1 && pos2) || (neg1 && neg2));
  endfunction

  logic                 en;
  logic signed [SW-1:0] u2;
  logic                 ray_nz;
  logic                 s1_vld_q, s1_first_q, s1_last_q;
  s1_edge_t             s1_a_q, s1_b_q;
  logic                 s2_vld_q, s2_first_q, s2_last_q;
  s2_edge_t             s2_a_q, s2_b_q;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q;
  pip_pkg::pip_out_t    out_data_q;

  // Pipeline moves unless a result waits on a stalled output
  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  assign u2     = SW'(q_data_i.qu) + SW'($signed({1'b0, ray_i}));
  assign ray_nz = (ray_i != '0);

  // Stage valids, result valid and running count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (en) begin
      s1_vld_q    <= q_valid_i;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= s2_vld_q && s2_last_q;
      if (s2_vld_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Stage 1: differences; stage 2: products
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_first_q <= q_data_i.first;
      s1_last_q  <= q_data_i.last;
      s1_a_q     <= prep(q_data_i.ea, q_data_i.a_vld, q_data_i.qu, q_data_i.qv, u2, ray_nz);
      s1_b_q     <= prep(q_data_i.eb, q_data_i.last, q_data_i.qu, q_data_i.qv, u2, ray_nz);
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_a_q     <= mult(s1_a_q);
      s2_b_q     <= mult(s1_b_q);
    end
  end

  // Stage 3: area signs and running count
  always_comb begin
    cnt_d = (s2_first_q ? '0 : cnt_q) + NW'(crosses(s2_a_q)) + NW'(crosses(s2_b_q));
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_vld_q && s2_last_q) begin
      out_data_q.inside_res     <= cnt_d[0];
      out_data_q.crossing_count <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- test/point_in_polygon_crossing_tb.sv -----
`timescale 1ns / 1ps
// Testbench for point_in_polygon_crossing: streams polygons, predicts each inside/count result.
// Depends on pip_pkg and the point_in_polygon_crossing RTL; self-contained otherwise.
module point_in_polygon_crossing_tb;

  localparam int     HALF_PERIOD = 6;
  localparam int     STALL_LIMIT = 3000;
  localparam int     HOLD_CYCLES = 300;
  localparam longint COORD_MAX   = (longint'(1) <<< (pip_pkg::COORD_W - 1)) - 1;
  localparam longint COORD_MIN   = -(longint'(1) <<< (pip_pkg::COORD_W - 1));
  localparam longint UNIT        = 65536;
  localparam logic [pip_pkg::RAY_W-1:0] RAY_MAX = {pip_pkg::RAY_W{1'b1}};

  // Crossing predictor and store of pending polygon results
  class pip_scoreboard;
    logic [pip_pkg::RAY_W-1:0] ray;
    bit                        opening;
    longint                    first_u, first_v, prev_u, prev_v, q_u, q_v;
    logic [pip_pkg::CNT_W-1:0] count;
    pip_pkg::pip_out_t         polygon_results[$];
    int                        mismatches;
    int                        checked;

    function new();
      ray        = pip_pkg::RAY_RESET;
      opening    = 1'b1;
      count      = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int sign_of(longint x);
      return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    // both strictly on the same side rejects the edge
    function bit same_side(int a, int b);
      return (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

    // 1 when edge (cu,cv)->(nu,nv) crosses the test segment
    function bit edge_counts(input longint cu, cv, nu, nv);
      longint u2, a1, a2;
      u2 = q_u + longint'(ray);
      if (cv == q_v && nv == q_v) return 1'b0;
      if (cv < nv && nv == q_v) return 1'b0;
      if (cv > nv && cv == q_v) return 1'b0;
      if (ray != 0 && same_side(sign_of(cv - q_v), sign_of(nv - q_v))) return 1'b0;
      a1 = (q_u - cu) * (nv - cv) - (nu - cu) * (q_v - cv);
      a2 = (u2 - cu) * (nv - cv) - (nu - cu) * (q_v - cv);
      return !same_side(sign_of(a1), sign_of(a2));
    endfunction

    // accepted vertex: advance the polygon, queue a result on the closing vertex
    function void note_vertex(pip_pkg::pip_in_t it);
      longint            vu, vv;
      pip_pkg::pip_out_t r;
      vu = it.vertex_u;
      vv = it.vertex_v;
      if (opening) begin
        q_u     = it.point_u;
        q_v     = it.point_v;
        first_u = vu;
        first_v = vv;
        count   = '0;
        opening = 1'b0;
      end else begin
        count = count + pip_pkg::CNT_W'(edge_counts(prev_u, prev_v, vu, vv));
      end
      prev_u = vu;
      prev_v = vv;
      if (it.last_vertex) begin
        count = count + pip_pkg::CNT_W'(edge_counts(vu, vv, first_u, first_v));
        r.inside_res     = count[0];
        r.crossing_count = count;
        polygon_results.insert(polygon_results.size(), r);
        opening = 1'b1;
        count   = '0;
      end
    endfunction

    function void check_result(pip_pkg::pip_out_t got);
      pip_pkg::pip_out_t want;
      if (polygon_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: got inside=%0b count=%0d",
                 $time, got.inside_res, got.crossing_count);
        return;
      end
      want = polygon_results.pop_front();
      checked++;
      if (got.inside_res !== want.inside_res) begin
        mismatches++;
        $display("%0t: inside_res expected %0b, got %0b",
                 $time, want.inside_res, got.inside_res);
      end
      if (got.crossing_count !== want.crossing_count) begin
        mismatches++;
        $display("%0t: crossing_count expected %0d, got %0d",
                 $time, want.crossing_count, got.crossing_count);
      end
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  pip_pkg::pip_in_t          in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  pip_pkg::pip_out_t         out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [pip_pkg::RAY_W-1:0] cfg_data_i  = '0;

  pip_scoreboard sb;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int vertices_sent = 0;
  int ray_writes    = 0;

  point_in_polygon_crossing dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Result side: random back-pressure, or a long counted hold when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Transfers are sampled mid-cycle, where inputs and outputs are settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_vertex(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic longint clamp_coord(longint x);
    if (x > COORD_MAX) return COORD_MAX;
    if (x < COORD_MIN) return COORD_MIN;
    return x;
  endfunction

  function automatic longint rand_span(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint rand_coord();
    logic signed [pip_pkg::COORD_W-1:0] c;
    c = pip_pkg::COORD_W'($urandom);
    return c;
  endfunction

  function automatic pip_pkg::pip_in_t mk_vertex(longint pu, pv, vu, vv, bit last);
    pip_pkg::pip_in_t it;
    it.point_u     = pip_pkg::COORD_W'(clamp_coord(pu));
    it.point_v     = pip_pkg::COORD_W'(clamp_coord(pv));
    it.vertex_u    = pip_pkg::COORD_W'(clamp_coord(vu));
    it.vertex_v    = pip_pkg::COORD_W'(clamp_coord(vv));
    it.last_vertex = last;
    return it;
  endfunction

  // One vertex transfer, with random gaps ahead of it
  task automatic send_vertex(input pip_pkg::pip_in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    vertices_sent++;
  endtask

  task automatic write_ray(input logic [pip_pkg::RAY_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    sb.ray = value;
    ray_writes++;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, let every pending result out, then idle before returning
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.polygon_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random polygon around a random query point; zigzag edges between successive vertices all cross
  task automatic send_polygon(input int n, input bit zigzag);
    longint qu, qv, s, ray_l, vu, vv;
    int     r;
    ray_l = longint'(sb.ray);
    r = $urandom_range(9);
    if (r == 0) begin
      qu = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      qv = $urandom_range(1) ? COORD_MAX : COORD_MIN;
    end else if (r == 1) begin
      qu = rand_coord();
      qv = rand_coord();
    end else begin
      qu = rand_span(-(longint'(1) <<< 22), longint'(1) <<< 22);
      qv = rand_span(-(longint'(1) <<< 22), longint'(1) <<< 22);
    end
    case ($urandom_range(4))
      0:       s = $urandom_range(4, 1);
      1:       s = 256;
      2:       s = ray_l + 1;
      3:       s = UNIT;
      default: s = longint'(1) <<< 20;
    endcase
    for (int k = 0; k < n; k++) begin
      if (zigzag) begin
        vu = qu + rand_span(0, ray_l);
        vv = (k % 2) ? qv - rand_span(1, s) : qv + rand_span(1, s);
      end else begin
        vv = ($urandom_range(4) == 0) ? qv : qv + rand_span(-s, s);
        r  = $urandom_range(9);
        if (r == 0) vu = qu;
        else if (r == 1) vu = qu + ray_l;
        else if (r == 2) vu = rand_coord();
        else vu = qu - s + rand_span(0, ray_l + 2 * s);
      end
      if (k == 0) send_vertex(mk_vertex(qu, qv, vu, vv, n == 1));
      else send_vertex(mk_vertex(rand_coord(), rand_coord(), vu, vv, k == n - 1));
    end
  endtask

  task automatic run_phase(input logic [pip_pkg::RAY_W-1:0] ray, input int snd_pct, rcv_pct,
                           input int vertex_goal, input bit with_zigzag, with_hold);
    int start, n, r;
    wait_drained();
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    write_ray(ray);
    if (with_hold) hold_seq++;
    start = vertices_sent;
    if (with_zigzag) send_polygon(131, 1'b1);
    while (vertices_sent - start < vertex_goal) begin
      r = $urandom_range(99);
      if (r < 70) n = $urandom_range(6, 1);
      else if (r < 95) n = $urandom_range(20, 7);
      else n = $urandom_range(70, 40);
      send_polygon(n, 1'b0);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct   = 36;
    receiver_idle_pct = 59;

    // Single-vertex polygons: extremes, then one on the query height
    send_vertex(mk_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1));
    send_vertex(mk_vertex(0, 0, 0, 0, 1'b1));
    // Unit square around the origin; later point fields are junk and ignored
    send_vertex(mk_vertex(0, 0, -UNIT, -UNIT, 1'b0));
    send_vertex(mk_vertex(COORD_MAX, COORD_MAX, UNIT, -UNIT, 1'b0));
    send_vertex(mk_vertex(COORD_MIN, COORD_MIN, UNIT, UNIT, 1'b0));
    send_vertex(mk_vertex(-1, 1, -UNIT, UNIT, 1'b1));
    // Horizontal edge at the query height, downward edge starting there,
    // upward edge ending there
    send_vertex(mk_vertex(0, 0, UNIT, 0, 1'b0));
    send_vertex(mk_vertex(0, 0, 5 * UNIT, 0, 1'b0));
    send_vertex(mk_vertex(0, 0, 5 * UNIT, -3 * UNIT, 1'b0));
    send_vertex(mk_vertex(0, 0, 2 * UNIT, -3 * UNIT, 1'b0));
    send_vertex(mk_vertex(0, 0, 2 * UNIT, 0, 1'b1));
    // Full-range square, query at the center, then on the right edge
    send_vertex(mk_vertex(0, 0, COORD_MIN, COORD_MIN, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MAX, COORD_MIN, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MIN, COORD_MAX, 1'b1));
    send_vertex(mk_vertex(COORD_MAX, 0, COORD_MIN, COORD_MIN, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MAX, COORD_MIN, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send_vertex(mk_vertex(0, 0, COORD_MIN, COORD_MAX, 1'b1));

    // Random polygons under several ray lengths and idle patterns
    run_phase(pip_pkg::RAY_W'(1), 36, 59, 155, 1'b0, 1'b0);
    run_phase(RAY_MAX, 36, 59, 155, 1'b0, 1'b0);
    run_phase(pip_pkg::RAY_W'($urandom_range(RAY_MAX, 1)), 59, 36, 155, 1'b0, 1'b0);
    run_phase(pip_pkg::RAY_RESET, 59, 36, 155, 1'b1, 1'b0);
    run_phase(pip_pkg::RAY_W'($urandom_range(4 * UNIT, 1)), 0, 0, 155, 1'b0, 1'b1);
    wait_drained();

    $display("tb: %0d vertices sent, %0d polygon results checked, %0d ray length writes",
             vertices_sent, sb.checked, ray_writes);
    $display("tb: %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
